@@ rtl/sab_pkg.sv @@
// ----------------------------------------------------------------------------
// sab_pkg: shared types for the suffix automaton builder
// Sequencer states and the field widths that the stream interface fixes.
// ----------------------------------------------------------------------------
package sab_pkg;

  localparam int OP_W   = 1;
  localparam int SYM_W  = 5;
  localparam int ST_W   = 11;
  localparam int LINK_W = 12;
  localparam int LEN_W  = 11;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_Q_RD,
    S_Q_WT,
    S_I_LEN,
    S_I_LENW,
    S_W_RD,
    S_W_WT,
    S_W_CHK,
    S_C_LEN,
    S_C_LENW,
    S_C_CHK,
    S_CP_RD,
    S_CP_WT,
    S_CP_WR,
    S_R_RD,
    S_R_WT,
    S_R_CHK,
    S_FIN,
    S_OUT
  } sab_state_t;

endpackage

@@ rtl/sab_mem.sv @@
// ----------------------------------------------------------------------------
// sab_mem: single-port RAM with registered read
// Reads every cycle, writes when we; read data appears on the next cycle.
// ----------------------------------------------------------------------------
module sab_mem #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8,
  parameter int AW    = 2
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write the addressed entry when we is set; it is read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/suffix_automaton_builder_unit.sv @@
// ----------------------------------------------------------------------------
// suffix_automaton_builder_unit: online suffix automaton construction
// A query reads the transition, link and length of its state; a rejected insert
// goes straight to the result. An insert writes the new length, walks the links,
// checks the met transition, and may copy a clone row and redirect states to it.
// One request at a time; ready again the cycle after the result is taken.
// Reset starts a clearing pass over the tables; no request is taken then.
// ----------------------------------------------------------------------------
module suffix_automaton_builder_unit
  import sab_pkg::*;
#(
  parameter int MAX_LEN    = 1024,
  parameter int NUM_STATES = 2048,
  parameter int ALPHABET   = 26
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // symbol[4:0], query_state[15:5]
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // new_state, new_link, cloned, clone_state,
                                 // status, query_target, query_link, query_length
);

  localparam int SA = $clog2(NUM_STATES);
  localparam int TD = NUM_STATES * ALPHABET;
  localparam int TA = $clog2(TD);
  localparam int CW = $clog2(ALPHABET + 1);
  localparam int LW = $clog2(MAX_LEN + 1);

  sab_state_t state, state_next;

  logic [SYM_W-1:0]  sym;
  logic [ST_W-1:0]   qs;
  logic [LINK_W-1:0] p;
  logic [ST_W-1:0]   np, qq, cl, last;
  logic [12:0]       cnt;
  logic [LW-1:0]     nins;
  logic              made_clone;
  logic [LEN_W-1:0]  lenp;
  logic [ST_W-1:0]   nlink;
  logic [TA-1:0]     clr;
  logic [CW-1:0]     ci;
  logic [ST_W-1:0]   cpy;
  logic [71:0]       res;

  // shared table, link and length ports
  logic              t_we, l_we, n_we;
  logic [TA-1:0]     t_addr;
  logic [SA-1:0]     l_addr, n_addr;
  logic [ST_W-1:0]   t_wd, t_rd;
  logic [LINK_W-1:0] l_wd, l_rd;
  logic [LEN_W-1:0]  n_wd, n_rd;

  sab_mem #(.DEPTH(TD), .WIDTH(ST_W), .AW(TA)) u_trans (
    .clk, .we(t_we), .addr(t_addr), .wdata(t_wd), .rdata(t_rd));
  sab_mem #(.DEPTH(NUM_STATES), .WIDTH(LINK_W), .AW(SA)) u_link (
    .clk, .we(l_we), .addr(l_addr), .wdata(l_wd), .rdata(l_rd));
  sab_mem #(.DEPTH(NUM_STATES), .WIDTH(LEN_W), .AW(SA)) u_len (
    .clk, .we(n_we), .addr(n_addr), .wdata(n_wd), .rdata(n_rd));

  function automatic logic [TA-1:0] taddr(logic [LINK_W-1:0] s, logic [SYM_W-1:0] c);
    logic [TA+SYM_W:0] a;
    a = (TA+SYM_W+1)'(s[SA-1:0]) * (TA+SYM_W+1)'(ALPHABET) + (TA+SYM_W+1)'(c);
    return a[TA-1:0];
  endfunction

  logic sym_ok, full, q_ok;
  assign sym_ok = 32'(sym) < ALPHABET;
  assign full   = (32'(nins) >= MAX_LEN) || (32'(cnt) + 2 >= NUM_STATES);
  assign q_ok   = (13'(qs) <= cnt) && (32'(qs) < NUM_STATES);
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = res;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (32'(clr) == TD - 1) state_next = S_IDLE;
      S_IDLE:   if (s_tvalid) state_next = (s_tuser == OP_QUERY) ? S_Q_RD : S_I_LEN;
      S_Q_RD:   state_next = S_Q_WT;
      S_Q_WT:   state_next = S_OUT;
      S_I_LEN:  state_next = (!sym_ok || full) ? S_OUT : S_I_LENW;
      S_I_LENW: state_next = S_W_RD;
      S_W_RD:   state_next = S_W_WT;
      S_W_WT:   state_next = S_W_CHK;
      S_W_CHK: begin
        if (t_rd == '0) state_next = (l_rd == '1) ? S_FIN : S_W_RD;
        else state_next = S_C_LEN;
      end
      S_C_LEN:  state_next = S_C_LENW;
      S_C_LENW: state_next = S_C_CHK;
      S_C_CHK:  state_next = (LEN_W'(lenp + 1'b1) == n_rd) ? S_FIN : S_CP_RD;
      S_CP_RD:  state_next = S_CP_WT;
      S_CP_WT:  state_next = S_CP_WR;
      S_CP_WR:  state_next = (32'(ci) == ALPHABET - 1) ? S_R_RD : S_CP_RD;
      S_R_RD:   state_next = S_R_WT;
      S_R_WT:   state_next = S_R_CHK;
      S_R_CHK: begin
        if (t_rd == qq && l_rd != '1) state_next = S_R_RD;
        else state_next = S_FIN;
      end
      S_FIN:    state_next = S_OUT;
      S_OUT:    if (m_tready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    t_we = 1'b0; l_we = 1'b0; n_we = 1'b0;
    t_addr = taddr(p, sym); t_wd = np;
    l_addr = p[SA-1:0]; l_wd = '0;
    n_addr = p[SA-1:0]; n_wd = '0;
    unique case (state)
      S_CLEAR: begin
        t_we = 1'b1; t_addr = clr; t_wd = '0;
        l_we = 32'(clr) < NUM_STATES; l_addr = clr[SA-1:0];
        l_wd = (clr == '0) ? '1 : '0;
        n_we = l_we; n_addr = clr[SA-1:0];
      end
      S_Q_RD: begin
        t_addr = taddr(LINK_W'(qs), sym); l_addr = qs[SA-1:0]; n_addr = qs[SA-1:0];
      end
      S_I_LEN:  n_addr = last[SA-1:0];
      S_I_LENW: begin
        n_we = 1'b1; n_addr = np[SA-1:0]; n_wd = LEN_W'(n_rd + 1'b1);
      end
      S_W_CHK: begin
        t_we = (t_rd == '0);
      end
      S_C_LEN:  n_addr = t_rd[SA-1:0];
      S_C_LENW: n_addr = qq[SA-1:0];
      S_C_CHK: begin
        l_addr = qq[SA-1:0];
        n_we = (LEN_W'(lenp + 1'b1) != n_rd);
        n_addr = SA'(cnt + 2'd2); n_wd = LEN_W'(lenp + 1'b1);
      end
      S_CP_RD: begin
        t_addr = taddr(LINK_W'(qq), SYM_W'(ci)); l_addr = qq[SA-1:0];
      end
      S_CP_WT: begin
        if (ci == '0) begin
          l_we = 1'b1; l_addr = cl[SA-1:0]; l_wd = l_rd;
        end
      end
      S_CP_WR: begin
        t_we = 1'b1; t_addr = taddr(LINK_W'(cl), SYM_W'(ci)); t_wd = cpy;
      end
      S_R_CHK: begin
        t_we = (t_rd == qq); t_wd = cl;
      end
      S_FIN: begin
        l_we = 1'b1; l_addr = np[SA-1:0]; l_wd = LINK_W'(nlink);
      end
      S_OUT: begin
        l_we = made_clone; l_addr = qq[SA-1:0]; l_wd = LINK_W'(cl);
      end
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr <= '0; cnt <= '0; nins <= '0; last <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: clr <= TA'(clr + 1'b1);
        S_IDLE: begin
          sym <= s_tdata[4:0]; qs <= s_tdata[15:5];
          p <= LINK_W'(last); made_clone <= 1'b0; cl <= '0; ci <= '0;
        end
        S_Q_WT: begin
          res <= q_ok ? {3'd0, n_rd, l_rd, (sym_ok ? t_rd : ST_W'(0)), 35'd0} : '0;
        end
        S_I_LEN: begin
          res <= {37'd0, (!sym_ok || full), 34'd0};
          if (sym_ok && !full) np <= ST_W'(cnt + 1'b1);
        end
        S_W_CHK: begin
          lenp <= n_rd;
          if (t_rd == '0) begin
            p <= l_rd;
            if (l_rd == '1) nlink <= '0;
          end else qq <= t_rd;
        end
        S_C_CHK: begin
          if (LEN_W'(lenp + 1'b1) == n_rd) nlink <= qq;
          else begin cl <= ST_W'(cnt + 2'd2); made_clone <= 1'b1; nlink <= ST_W'(cnt + 2'd2); end
        end
        S_CP_WT:  cpy <= t_rd;
        S_CP_WR:  ci <= CW'(ci + 1'b1);
        S_R_CHK:  if (t_rd == qq) p <= l_rd;
        S_FIN: begin
          last <= np; nins <= LW'(nins + 1'b1);
          cnt <= made_clone ? 13'(cnt + 2'd2) : 13'(cnt + 1'b1);
          res <= {38'd0, cl, made_clone, nlink, np};
        end
        default: ;
      endcase
    end
  end

  // length of p is read alongside the link during the walk
  // (n_addr defaults to p, so n_rd in S_W_CHK holds len[p])

  // result only on the output state
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("busy and ready together");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result lost");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) < NUM_STATES) else $error("state count overflow");

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for suffix_automaton_builder_unit
// Drives insert and query requests over the slave stream and predicts every
// result with an internal suffix automaton. Each result on the master stream
// is checked field by field against the oldest prediction. Both streams stall
// at random until the final phase, which runs without stalls.
// ----------------------------------------------------------------------------
module testbench
  import sab_pkg::*;
();

  localparam int NSTATES  = 2048;
  localparam int ALPHA    = 26;
  localparam int MAXLEN   = 1024;
  localparam int WD_LIMIT = 300000;

  typedef struct packed {
    logic [2:0]        pad;
    logic [LEN_W-1:0]  query_length;
    logic [LINK_W-1:0] query_link;
    logic [ST_W-1:0]   query_target;
    logic              status;
    logic [ST_W-1:0]   clone_state;
    logic              cloned;
    logic [ST_W-1:0]   new_link;
    logic [ST_W-1:0]   new_state;
  } sam_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;

  // automaton copy held by the predictor
  int          trans_row [NSTATES*ALPHA];
  int          link_of [NSTATES];
  int          len_of [NSTATES];
  int          tail_state;
  int          num_states;
  int          num_symbols;

  sam_result_t expected_results[$];
  int          fails = 0;
  bit          quiet = 1'b0;
  int          idle_cycles = 0;

  suffix_automaton_builder_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit sam_full();
    return (num_symbols >= MAXLEN) || (num_states + 2 >= NSTATES);
  endfunction

  // extend or read the automaton and return the answer
  function automatic sam_result_t sam_apply(logic op, logic [SYM_W-1:0] sym,
                                            logic [ST_W-1:0] qs);
    sam_result_t r;
    int np, p, q, cl;
    r = '0;
    if (op == OP_QUERY) begin
      if (qs <= num_states) begin
        r.query_target = (sym < ALPHA) ? ST_W'(trans_row[qs*ALPHA+sym]) : ST_W'(0);
        r.query_link   = LINK_W'(link_of[qs]);
        r.query_length = LEN_W'(len_of[qs]);
      end
      return r;
    end
    if (sym >= ALPHA || sam_full()) begin
      r.status = 1'b1;
      return r;
    end
    num_states++;
    np = num_states;
    cl = 0;
    p = tail_state;
    len_of[np] = len_of[tail_state] + 1;
    while (p != -1 && trans_row[p*ALPHA+sym] == 0) begin
      trans_row[p*ALPHA+sym] = np;
      p = link_of[p];
    end
    if (p == -1) begin
      link_of[np] = 0;
    end else begin
      q = trans_row[p*ALPHA+sym];
      if (len_of[p] + 1 == len_of[q]) begin
        link_of[np] = q;
      end else begin
        num_states++;
        cl = num_states;
        len_of[cl] = len_of[p] + 1;
        for (int a = 0; a < ALPHA; a++) trans_row[cl*ALPHA+a] = trans_row[q*ALPHA+a];
        link_of[cl] = link_of[q];
        while (p != -1 && trans_row[p*ALPHA+sym] == q) begin
          trans_row[p*ALPHA+sym] = cl;
          p = link_of[p];
        end
        link_of[q]  = cl;
        link_of[np] = cl;
      end
    end
    tail_state = np;
    num_symbols++;
    r.new_state   = ST_W'(np);
    r.new_link    = ST_W'(link_of[np]);
    r.cloned      = (cl != 0);
    r.clone_state = ST_W'(cl);
    return r;
  endfunction

  task automatic report(string field, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", field, got, want);
    fails++;
  endtask

  // check each result against the oldest prediction
  always @(posedge clk) begin
    sam_result_t g, e;
    if (!rst && m_tvalid && m_tready) begin
      g = m_tdata;
      if (expected_results.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        e = expected_results.pop_front();
        if (g.new_state != e.new_state)
          report("new_state", int'(g.new_state), int'(e.new_state));
        if (g.new_link != e.new_link)
          report("new_link", int'(g.new_link), int'(e.new_link));
        if (g.cloned != e.cloned) report("cloned", int'(g.cloned), int'(e.cloned));
        if (g.clone_state != e.clone_state)
          report("clone_state", int'(g.clone_state), int'(e.clone_state));
        if (g.status != e.status) report("status", int'(g.status), int'(e.status));
        if (g.query_target != e.query_target)
          report("query_target", int'(g.query_target), int'(e.query_target));
        if (g.query_link != e.query_link)
          report("query_link", $signed(g.query_link), $signed(e.query_link));
        if (g.query_length != e.query_length)
          report("query_length", int'(g.query_length), int'(e.query_length));
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // stall the result side in bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (quiet) begin
        m_tready <= 1'b1;
      end else begin
        n = $urandom_range(1, 18);
        m_tready <= $urandom_range(0, 2) != 0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // drive one request from a falling edge and hold it until taken
  task automatic send_item(logic op, logic [SYM_W-1:0] sym, logic [ST_W-1:0] qs);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {qs, sym};
    forever begin
      @(posedge clk);
      if (s_tready) break;
    end
    expected_results.insert(expected_results.size(), sam_apply(op, sym, qs));
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    logic [SYM_W-1:0] word[8] = '{0, 0, 1, 0, 1, 1, 0, 25};
    send_item(OP_QUERY, 0, 0);
    send_item(OP_QUERY, 31, 2047);
    foreach (word[i]) send_item(OP_INSERT, word[i], 0);
    send_item(OP_INSERT, 26, 0);
    send_item(OP_INSERT, 31, 2047);
    for (int s = 0; s <= 4; s++) send_item(OP_QUERY, 0, ST_W'(s));
    send_item(OP_QUERY, 1, 3);
    send_item(OP_QUERY, 25, 0);
    send_item(OP_QUERY, 30, 1);
    send_item(OP_QUERY, 0, 2047);
    send_item(OP_QUERY, 0, ST_W'(num_states + 1));
  endtask

  task automatic test_random(int count);
    logic [SYM_W-1:0] sym;
    logic [ST_W-1:0] qs;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        sym = ($urandom_range(0, 19) == 0) ? SYM_W'($urandom_range(0, 31))
                                           : SYM_W'($urandom_range(0, 2));
        send_item(OP_INSERT, sym, ST_W'($urandom_range(0, 2047)));
      end else begin
        qs  = ($urandom_range(0, 4) == 0) ? ST_W'($urandom_range(0, 2047))
                                          : ST_W'($urandom_range(0, num_states));
        sym = ($urandom_range(0, 4) == 0) ? SYM_W'($urandom_range(0, 31))
                                          : SYM_W'($urandom_range(0, 2));
        send_item(OP_QUERY, sym, qs);
      end
    end
  endtask

  task automatic test_pause();
    drain();
    test_random(20);
  endtask

  // run without stalls on a wider alphabet, then probe the automaton
  task automatic test_tail();
    quiet = 1'b1;
    for (int i = 0; i < 100; i++) send_item(OP_INSERT, SYM_W'($urandom_range(0, 3)), 0);
    send_item(OP_QUERY, 0, ST_W'(num_states));
    send_item(OP_QUERY, 3, ST_W'(tail_state));
    send_item(OP_QUERY, 1, 2047);
  endtask

  initial begin
    for (int i = 0; i < NSTATES*ALPHA; i++) trans_row[i] = 0;
    for (int i = 0; i < NSTATES; i++) begin
      link_of[i] = 0;
      len_of[i]  = 0;
    end
    link_of[0]  = -1;
    tail_state  = 0;
    num_states  = 0;
    num_symbols = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random(300);
    test_pause();
    test_random(300);
    test_tail();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
